>>> hw/rtl/sri_pkg.sv
// Shared types and constants for the Sellmeier refractive index unit.
`default_nettype none

package sri_pkg;

  localparam int WL_W    = 32;
  localparam int L2_W    = 64;
  localparam int ND_W    = 30;
  localparam int TERM_QW = 40;
  localparam int FB_NUMW = 61;
  localparam int FB_QW   = 55;

  localparam logic [ND_W-1:0]    ONE_Q28   = 30'h1000_0000;
  localparam logic [29:0]        P_Q30     = 30'd562270382;
  localparam logic [30:0]        Q_Q30     = 31'd1628698843;
  localparam logic [WL_W-1:0]    SAT_INDEX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_B1   = 3'd0,
    CFG_B2   = 3'd1,
    CFG_B3   = 3'd2,
    CFG_C1   = 3'd3,
    CFG_C2   = 3'd4,
    CFG_C3   = 3'd5,
    CFG_ND   = 3'd6,
    CFG_ABBE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_MUL,
    CD_DIV
  } cd_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sri_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`default_nettype none

module sri_div_pipe #(
  parameter int DW = 64,
  parameter int QW = 40,
  parameter int TW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [DW+QW-1:0] in_num,
  input  wire logic [DW-1:0]    in_den,
  input  wire logic [TW-1:0]    in_tag,
  output logic                  out_vld,
  output logic [QW-1:0]         out_quo,
  output logic                  out_ovf,
  output logic [TW-1:0]         out_tag
);

  localparam int NW = DW + QW;

  logic          vld_r [0:QW];
  logic [NW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic          ovf_r [0:QW];
  logic [TW-1:0] tag_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  // quotient >= 2^QW, or zero divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_num;
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      ovf_r[0] <= (in_den == '0) || (in_num >= {in_den, {QW{1'b0}}});
      tag_r[0] <= in_tag;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int K = QW - s;
    logic [NW-1:0] trial;
    logic          fit;

    assign trial = {{QW{1'b0}}, den_r[s-1]} << K;
    assign fit   = rem_r[s-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= fit ? rem_r[s-1] - trial : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        quo_r[s] <= quo_r[s-1] | (QW'(fit) << K);
        ovf_r[s] <= ovf_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = quo_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_tag = tag_r[QW];

endmodule

`default_nettype wire

>>> hw/rtl/sri_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module sri_sqrt_pipe #(
  parameter int RW = 32,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [2*RW-1:0] in_x,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_vld,
  output logic [RW-1:0]        out_root,
  output logic [TW-1:0]        out_tag
);

  localparam int XW = 2 * RW;

  logic          vld_r  [0:RW];
  logic [XW-1:0] rem_r  [0:RW];
  logic [RW-1:0] root_r [0:RW];
  logic [TW-1:0] tag_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_x;
      root_r[0] <= '0;
      tag_r[0]  <= in_tag;
    end
  end

  // rem holds x - root^2; (root + 2^i)^2 - root^2 = root*2^(i+1) + 2^(2i)
  for (genvar s = 1; s <= RW; s++) begin : g_stage
    localparam int I = RW - s;
    logic [XW-1:0] trial;
    logic          fit;

    assign trial = ({{RW{1'b0}}, root_r[s-1]} << (I + 1)) | (XW'(1) << (2 * I));
    assign fit   = rem_r[s-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= fit ? rem_r[s-1] - trial : rem_r[s-1];
        root_r[s] <= root_r[s-1] | (RW'(fit) << I);
        tag_r[s]  <= tag_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_tag  = tag_r[RW];

endmodule

`default_nettype wire

>>> hw/rtl/sri_coef_div.sv
// Serial divider that derives the Cauchy fallback coefficients from nd and vd.
`default_nettype none

module sri_coef_div
  import sri_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [ND_W-1:0] index_d_line,
  input  wire logic [31:0]     abbe_number,
  output logic                 busy,
  output logic [FB_QW-1:0]     bq,
  output logic [FB_QW-1:0]     cq
);

  localparam int CNT_W = $clog2(FB_NUMW);
  localparam int DEN_W = 38;

  cd_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [FB_NUMW-1:0] num_a_r, num_b_r, qa_r, qb_r;
  logic [DEN_W-1:0]   den_r, rem_a_r, rem_b_r;
  logic [ND_W-1:0]    dmag;
  logic [DEN_W:0]     ta, tb;
  logic               fit_a, fit_b, last, do_load, do_step;

  assign dmag  = (index_d_line >= ONE_Q28) ? index_d_line - ONE_Q28 : ONE_Q28 - index_d_line;
  assign ta    = {rem_a_r, num_a_r[FB_NUMW-1]};
  assign tb    = {rem_b_r, num_b_r[FB_NUMW-1]};
  assign fit_a = ta >= {1'b0, den_r};
  assign fit_b = tb >= {1'b0, den_r};
  assign last  = cnt_r == CNT_W'(FB_NUMW - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CD_IDLE: if (start) state_nxt = CD_MUL;
      CD_MUL:  state_nxt = start ? CD_MUL : CD_DIV;
      CD_DIV: begin
        if (start) state_nxt = CD_MUL;
        else if (last) state_nxt = CD_IDLE;
      end
      default: state_nxt = CD_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    do_load = 1'b0;
    do_step = 1'b0;
    unique case (state_r)
      CD_IDLE: busy = 1'b0;
      CD_MUL:  do_load = 1'b1;
      CD_DIV:  do_step = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      num_a_r <= FB_NUMW'({31'b0, dmag} * {31'b0, P_Q30});
      num_b_r <= FB_NUMW'({31'b0, dmag} * {30'b0, Q_Q30});
      den_r   <= {abbe_number, 6'b0};
      rem_a_r <= '0;
      rem_b_r <= '0;
      cnt_r   <= '0;
    end else if (do_step) begin
      rem_a_r <= fit_a ? DEN_W'(ta - {1'b0, den_r}) : ta[DEN_W-1:0];
      rem_b_r <= fit_b ? DEN_W'(tb - {1'b0, den_r}) : tb[DEN_W-1:0];
      qa_r    <= {qa_r[FB_NUMW-2:0], fit_a};
      qb_r    <= {qb_r[FB_NUMW-2:0], fit_b};
      num_a_r <= {num_a_r[FB_NUMW-2:0], 1'b0};
      num_b_r <= {num_b_r[FB_NUMW-2:0], 1'b0};
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  assign bq = qa_r[FB_QW-1:0];
  assign cq = qb_r[FB_QW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/sellmeier_refractive_index_unit.sv
// Top level of the Sellmeier refractive index unit.
// One wavelength (Q8.24 um) per cycle in while in_stall is low, one index (Q4.28) plus a
// pole/saturation flag out, via: square, Bi*l2 partial products, sum, a 41-stage divider
// per Sellmeier term, combine, a 33-stage square root and the output register. When all
// six Sellmeier registers are zero the first-order Cauchy fallback from nd and vd is used.
// After any configuration write the input stalls while a serial divider rebuilds the
// fallback coefficients. A stalled output freezes the whole pipeline.
`default_nettype none

module sellmeier_refractive_index_unit
  import sri_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [WL_W-1:0] in_wavelength,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [WL_W-1:0]      out_index,
  output logic                 out_pole_hit,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data
);

  localparam int NUM_W = L2_W + TERM_QW;

  logic [31:0]     coef_b_r [3];
  logic [31:0]     pole_c_r [3];
  logic [ND_W-1:0] nd_r;
  logic [31:0]     abbe_r;

  logic             en, busy, sell_mode, cfg_we, nd_neg;
  logic [FB_QW-1:0] bq, cq;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        coef_b_r[i] <= '0;
        pole_c_r[i] <= '0;
      end
      nd_r   <= ONE_Q28;
      abbe_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_B1:   coef_b_r[0] <= cfg_data;
        CFG_B2:   coef_b_r[1] <= cfg_data;
        CFG_B3:   coef_b_r[2] <= cfg_data;
        CFG_C1:   pole_c_r[0] <= cfg_data;
        CFG_C2:   pole_c_r[1] <= cfg_data;
        CFG_C3:   pole_c_r[2] <= cfg_data;
        CFG_ND:   nd_r        <= cfg_data[ND_W-1:0];
        CFG_ABBE: abbe_r      <= cfg_data;
        default:  abbe_r      <= abbe_r;
      endcase
    end
  end

  sri_coef_div u_coef (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (cfg_we),
    .index_d_line (nd_r),
    .abbe_number  (abbe_r),
    .busy         (busy),
    .bq           (bq),
    .cq           (cq)
  );

  assign sell_mode = |{coef_b_r[0], coef_b_r[1], coef_b_r[2],
                       pole_c_r[0], pole_c_r[1], pole_c_r[2]};
  assign nd_neg    = nd_r < ONE_Q28;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en || busy;

  // stage 1: l2 = w^2
  logic            v1_r;
  logic [L2_W-1:0] l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r <= {32'b0, in_wavelength} * {32'b0, in_wavelength};
    end
  end

  // stage 2: Bi*l2 halves and |l2 - Ci|
  logic            v2_r;
  logic [L2_W-1:0] l2_2_r;
  logic [63:0]     pp_lo_r [3];
  logic [63:0]     pp_hi_r [3];
  logic [L2_W-1:0] mag2_r  [3];
  logic            neg2_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_2_r <= l2_r;
    end
  end

  for (genvar t = 0; t < 3; t++) begin : g_term
    logic [L2_W-1:0] pole_ext;
    logic            neg;

    assign pole_ext = {8'b0, pole_c_r[t], 24'b0};
    assign neg      = l2_r < pole_ext;

    always_ff @(posedge clk) begin
      if (en) begin
        pp_lo_r[t] <= {32'b0, coef_b_r[t]} * {32'b0, l2_r[31:0]};
        pp_hi_r[t] <= {32'b0, coef_b_r[t]} * {32'b0, l2_r[63:32]};
        mag2_r[t]  <= neg ? pole_ext - l2_r : l2_r - pole_ext;
        neg2_r[t]  <= neg;
      end
    end
  end

  // stage 3: full numerators; term 0 carries the fallback division
  logic             v3_r;
  logic [NUM_W-1:0] num3_r [3];
  logic [L2_W-1:0]  den3_r [3];
  logic             neg3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num3_r[i] <= NUM_W'({32'b0, pp_lo_r[i]} + {pp_hi_r[i], 32'b0});
        den3_r[i] <= mag2_r[i];
        neg3_r[i] <= neg2_r[i];
      end
      if (!sell_mode) begin
        num3_r[0] <= {2'b0, bq[FB_QW-2:0], 48'b0};
        den3_r[0] <= l2_2_r;
      end
    end
  end

  logic               dv_vld [3];
  logic [TERM_QW-1:0] dv_quo [3];
  logic               dv_ovf [3];
  logic [0:0]         dv_neg [3];

  for (genvar t = 0; t < 3; t++) begin : g_div
    sri_div_pipe #(
      .DW (L2_W),
      .QW (TERM_QW),
      .TW (1)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (v3_r),
      .in_num  (num3_r[t]),
      .in_den  (den3_r[t]),
      .in_tag  (neg3_r[t]),
      .out_vld (dv_vld[t]),
      .out_quo (dv_quo[t]),
      .out_ovf (dv_ovf[t]),
      .out_tag (dv_neg[t])
    );
  end

  // stage 4: sum of terms, fallback delta
  logic               v4_r;
  logic signed [43:0] n2_r, n2_sum;
  logic               sat4_r, sat_sum;
  logic signed [57:0] nfb_r, nfb;
  logic               fsat_r;
  logic signed [56:0] delta;

  always_comb begin
    n2_sum  = 44'sd268435456;
    sat_sum = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (coef_b_r[i] != '0) begin
        sat_sum = sat_sum | dv_ovf[i];
        if (dv_neg[i][0]) n2_sum = n2_sum - $signed({4'b0, dv_quo[i]});
        else n2_sum = n2_sum + $signed({4'b0, dv_quo[i]});
      end
    end
  end

  assign delta = $signed({17'b0, dv_quo[0]}) - $signed({2'b0, cq});
  assign nfb   = nd_neg ? $signed({28'b0, nd_r}) - 58'(delta)
                        : $signed({28'b0, nd_r}) + 58'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= dv_vld[0] && dv_vld[1] && dv_vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r   <= n2_sum;
      sat4_r <= sat_sum;
      nfb_r  <= nfb;
      fsat_r <= dv_ovf[0];
    end
  end

  // stage 5: clamp n^2, finish fallback, feed the root
  logic signed [43:0] n2c;
  logic               sel_sat;
  logic [WL_W-1:0]    fb_idx;
  logic               fb_flag;
  logic [63:0]        sq_x;

  assign n2c     = (n2_r < 44'sd268435456) ? 44'sd268435456 : n2_r;
  assign sel_sat = sat4_r || (n2c >= 44'sd68719476736);
  assign sq_x    = {n2c[35:0], 28'b0};

  always_comb begin
    fb_idx  = nfb_r[WL_W-1:0];
    fb_flag = 1'b0;
    if (abbe_r == '0) begin
      fb_idx = {2'b0, nd_r};
    end else if (fsat_r) begin
      fb_idx  = SAT_INDEX;
      fb_flag = 1'b1;
    end else if (nfb_r < 0) begin
      fb_idx  = '0;
      fb_flag = 1'b1;
    end else if (nfb_r > $signed({26'b0, SAT_INDEX})) begin
      fb_idx  = SAT_INDEX;
      fb_flag = 1'b1;
    end
  end

  logic            sq_vld;
  logic [WL_W-1:0] sq_root;
  logic [33:0]     sq_tag;

  sri_sqrt_pipe #(
    .RW (WL_W),
    .TW (34)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v4_r),
    .in_x     (sq_x),
    .in_tag   ({fb_idx, fb_flag, sel_sat}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // output register
  logic            out_valid_r;
  logic [WL_W-1:0] out_index_r, out_index_nxt;
  logic            out_pole_hit_r, out_pole_hit_nxt;

  always_comb begin
    if (!sell_mode) begin
      out_index_nxt    = sq_tag[33:2];
      out_pole_hit_nxt = sq_tag[1];
    end else if (sq_tag[0]) begin
      out_index_nxt    = SAT_INDEX;
      out_pole_hit_nxt = 1'b1;
    end else begin
      out_index_nxt    = sq_root;
      out_pole_hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_index_r    <= out_index_nxt;
      out_pole_hit_r <= out_pole_hit_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_pole_hit = out_pole_hit_r;

endmodule

`default_nettype wire
